// File: rtl/dfm_pkg.sv
// Shared types, codes and constants for the deauth frame monitor.
// No dependencies; used by dfm_engine, deauth_frame_monitor_core and the bench.
package dfm_pkg;

   localparam int LOG_DEPTH_DEFAULT = 32;

   typedef enum logic [1:0] {
      CMD_FRAME   = 2'd0,
      CMD_TICK    = 2'd1,
      CMD_DISMISS = 2'd2,
      CMD_READ    = 2'd3
   } cmd_type;

   // configuration register indexes
   localparam logic [1:0] CSR_UPDATE_INTERVAL = 2'd0;
   localparam logic [1:0] CSR_HOP_INTERVAL    = 2'd1;
   localparam logic [1:0] CSR_SPIKE_THRESHOLD = 2'd2;
   localparam logic [1:0] CSR_AUTO_HOP        = 2'd3;

   localparam logic [15:0] UPDATE_INTERVAL_RESET = 16'd1000;
   localparam logic [15:0] HOP_INTERVAL_RESET    = 16'd500;
   localparam logic [15:0] SPIKE_THRESHOLD_RESET = 16'd10;
   localparam logic        AUTO_HOP_RESET        = 1'b1;

   localparam logic [15:0] MIN_HDR_LEN   = 16'd24;
   localparam logic [1:0]  TYPE_MGMT     = 2'b00;
   localparam logic [3:0]  SUB_DEAUTH    = 4'hC;
   localparam logic [3:0]  SUB_DISASSOC  = 4'hA;
   localparam logic [3:0]  FIRST_CHANNEL = 4'd1;
   localparam logic [3:0]  LAST_CHANNEL  = 4'd13;
   localparam logic [15:0] TIMER_MAX     = 16'hFFFF;

   typedef struct packed {
      logic              kind;         // 0 deauth, 1 disassoc
      logic [47:0]       transmitter;
      logic [47:0]       receiver;
      logic signed [7:0] rssi;
   } log_entry_type;

   // state after one transaction, as handed to the result register
   typedef struct packed {
      logic        alert;
      logic [31:0] spike_total;
      logic [31:0] frames_seen;
      logic [31:0] deauth_seen;
      logic [31:0] disassoc_seen;
      logic [5:0]  log_fill;
      logic [3:0]  channel;
      logic        entry_hit;      // read of a non-empty log
   } status_type;

endpackage

// File: rtl/dfm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dfm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/dfm_engine.sv
// Monitor state, configuration registers and event log for one transaction
// per cycle. Depends on dfm_pkg and dfm_ram.
module dfm_engine #(
   parameter int LOG_DEPTH = dfm_pkg::LOG_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_write_data,
   input  logic                  fire,
   input  dfm_pkg::cmd_type      cmd,
   input  logic [7:0]            frame_control,
   input  logic [15:0]           frame_length,
   input  logic [47:0]           receiver_address,
   input  logic [47:0]           transmitter_address,
   input  logic signed [7:0]     signal_strength,
   input  logic [4:0]            log_position,
   output dfm_pkg::status_type   status,
   output dfm_pkg::log_entry_type entry
);

   localparam int AW = $clog2(LOG_DEPTH);
   localparam int FW = $clog2(LOG_DEPTH + 1);
   localparam int PW = (FW > 5) ? FW : 5;

   logic [15:0] upd_iv_ff, hop_iv_ff, thr_ff;
   logic        auto_hop_ff;

   logic [31:0]   frames_ff, frames_in;
   logic [31:0]   deauth_ff, deauth_in;
   logic [31:0]   disassoc_ff, disassoc_in;
   logic [31:0]   interval_ff, interval_in;
   logic [31:0]   spike_ff, spike_in;
   logic          alert_ff, alert_in;
   logic [AW-1:0] head_ff, head_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [3:0]    channel_ff, channel_in;
   logic [15:0]   hop_el_ff, hop_el_in;
   logic [15:0]   upd_el_ff, upd_el_in;

   logic          is_mgmt, is_deauth, is_disassoc, log_write;
   logic [15:0]   hop_sat, upd_sat;
   logic [3:0]    channel_next;
   logic [AW-1:0] head_next;
   logic [PW-1:0] pos_ext, fill_ext, pos_clamp;
   logic [AW:0]   slot_sum;
   logic [AW-1:0] rd_slot;
   dfm_pkg::log_entry_type wr_entry;

   // frame classification
   assign is_mgmt     = (frame_length >= dfm_pkg::MIN_HDR_LEN) &&
                        (frame_control[3:2] == dfm_pkg::TYPE_MGMT);
   assign is_deauth   = is_mgmt && (frame_control[7:4] == dfm_pkg::SUB_DEAUTH);
   assign is_disassoc = is_mgmt && (frame_control[7:4] == dfm_pkg::SUB_DISASSOC);
   assign log_write   = fire && (cmd == dfm_pkg::CMD_FRAME) && (is_deauth || is_disassoc);

   assign hop_sat = (hop_el_ff == dfm_pkg::TIMER_MAX) ? hop_el_ff : hop_el_ff + 16'd1;
   assign upd_sat = (upd_el_ff == dfm_pkg::TIMER_MAX) ? upd_el_ff : upd_el_ff + 16'd1;
   assign channel_next = (channel_ff == dfm_pkg::LAST_CHANNEL) ? dfm_pkg::FIRST_CHANNEL
                                                               : channel_ff + 4'd1;
   assign head_next = (head_ff == AW'(LOG_DEPTH - 1)) ? '0 : head_ff + AW'(1);

   // newest-first slot: head - 1 - pos, modulo depth, position clamped to fill - 1
   assign pos_ext   = PW'(log_position);
   assign fill_ext  = PW'(fill_ff);
   assign pos_clamp = (pos_ext >= fill_ext) ? fill_ext - PW'(1) : pos_ext;
   assign slot_sum  = {1'b0, head_ff} + (AW+1)'(LOG_DEPTH - 1) - {1'b0, pos_clamp[AW-1:0]};
   assign rd_slot   = (slot_sum >= (AW+1)'(LOG_DEPTH)) ?
                      AW'(slot_sum - (AW+1)'(LOG_DEPTH)) : slot_sum[AW-1:0];

   always_comb begin
      frames_in   = frames_ff;
      deauth_in   = deauth_ff;
      disassoc_in = disassoc_ff;
      interval_in = interval_ff;
      spike_in    = spike_ff;
      alert_in    = alert_ff;
      head_in     = head_ff;
      fill_in     = fill_ff;
      channel_in  = channel_ff;
      hop_el_in   = hop_el_ff;
      upd_el_in   = upd_el_ff;
      if (fire) begin
         case (cmd)
            dfm_pkg::CMD_FRAME: begin
               if (is_mgmt) begin
                  frames_in = frames_ff + 32'd1;
               end
               if (is_deauth) begin
                  deauth_in   = deauth_ff + 32'd1;
                  interval_in = interval_ff + 32'd1;
               end
               if (is_disassoc) begin
                  disassoc_in = disassoc_ff + 32'd1;
               end
               if (is_deauth || is_disassoc) begin
                  head_in = head_next;
                  if (fill_ff < FW'(LOG_DEPTH)) begin
                     fill_in = fill_ff + FW'(1);
                  end
               end
            end
            dfm_pkg::CMD_TICK: begin
               hop_el_in = hop_sat;
               upd_el_in = upd_sat;
               // timers keep running while alerting; hop and check are held off
               if (!alert_ff) begin
                  if (auto_hop_ff && (hop_sat >= hop_iv_ff)) begin
                     channel_in = channel_next;
                     hop_el_in  = '0;
                  end
                  if (upd_sat >= upd_iv_ff) begin
                     upd_el_in   = '0;
                     interval_in = '0;
                     if (interval_ff >= {16'd0, thr_ff}) begin
                        spike_in = interval_ff;
                        alert_in = 1'b1;
                     end
                  end
               end
            end
            dfm_pkg::CMD_DISMISS: begin
               alert_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff   <= '0;
         deauth_ff   <= '0;
         disassoc_ff <= '0;
         interval_ff <= '0;
         spike_ff    <= '0;
         alert_ff    <= 1'b0;
         head_ff     <= '0;
         fill_ff     <= '0;
         channel_ff  <= dfm_pkg::FIRST_CHANNEL;
         hop_el_ff   <= '0;
         upd_el_ff   <= '0;
      end else begin
         frames_ff   <= frames_in;
         deauth_ff   <= deauth_in;
         disassoc_ff <= disassoc_in;
         interval_ff <= interval_in;
         spike_ff    <= spike_in;
         alert_ff    <= alert_in;
         head_ff     <= head_in;
         fill_ff     <= fill_in;
         channel_ff  <= channel_in;
         hop_el_ff   <= hop_el_in;
         upd_el_ff   <= upd_el_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upd_iv_ff   <= dfm_pkg::UPDATE_INTERVAL_RESET;
         hop_iv_ff   <= dfm_pkg::HOP_INTERVAL_RESET;
         thr_ff      <= dfm_pkg::SPIKE_THRESHOLD_RESET;
         auto_hop_ff <= dfm_pkg::AUTO_HOP_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            dfm_pkg::CSR_UPDATE_INTERVAL: upd_iv_ff   <= csr_write_data;
            dfm_pkg::CSR_HOP_INTERVAL:    hop_iv_ff   <= csr_write_data;
            dfm_pkg::CSR_SPIKE_THRESHOLD: thr_ff      <= csr_write_data;
            dfm_pkg::CSR_AUTO_HOP:        auto_hop_ff <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   assign wr_entry.kind        = is_disassoc;
   assign wr_entry.transmitter = transmitter_address;
   assign wr_entry.receiver    = receiver_address;
   assign wr_entry.rssi        = signal_strength;

   dfm_ram #(
      .WIDTH ($bits(dfm_pkg::log_entry_type)),
      .DEPTH (LOG_DEPTH)
   ) u_log_ram (
      .clock   (clock),
      .wr_en   (log_write),
      .wr_addr (head_ff),
      .wr_data (wr_entry),
      .rd_en   (fire),
      .rd_addr (rd_slot),
      .rd_data (entry)
   );

   assign status.alert         = alert_in;
   assign status.spike_total   = spike_in;
   assign status.frames_seen   = frames_in;
   assign status.deauth_seen   = deauth_in;
   assign status.disassoc_seen = disassoc_in;
   assign status.log_fill      = 6'(fill_in);
   assign status.channel       = channel_in;
   assign status.entry_hit     = (cmd == dfm_pkg::CMD_READ) && (fill_ff != '0);

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(LOG_DEPTH))
      else $error("log fill above depth");

   a_channel_range: assert property (@(posedge clock) disable iff (reset)
      (channel_ff >= dfm_pkg::FIRST_CHANNEL) && (channel_ff <= dfm_pkg::LAST_CHANNEL))
      else $error("channel out of range");

   a_no_hop_alerting: assert property (@(posedge clock) disable iff (reset)
      (fire && (cmd == dfm_pkg::CMD_TICK) && alert_ff) |=> (channel_ff == $past(channel_ff)))
      else $error("channel hopped while alert latched");

   a_dismiss_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && (cmd == dfm_pkg::CMD_DISMISS)) |=> !alert_ff)
      else $error("alert still set after dismiss");

endmodule

// File: rtl/deauth_frame_monitor_core.sv
// Top level of the deauth frame monitor: input register, result register and
// handshake. Depends on dfm_pkg and dfm_engine.
//
//   port group | direction | handshake                 | contents
//   req_*      | in        | req_valid / req_stall     | frame, tick, dismiss, log read
//   rsp_*      | out       | rsp_valid / rsp_stall     | counters, alert, channel, entry
//   csr_*      | in        | csr_write_enable          | interval, threshold, hop regs
//
// One transaction per cycle sustained while rsp_stall is low; a result is offered once its
// request has passed the input register, then the result register and log RAM read.
// The log RAM read port is registered together with the result register.
// A stalled result holds while the input register still takes one more request.
// Reset is synchronous, active high; the log contents are not cleared.
module deauth_frame_monitor_core #(
   parameter int LOG_DEPTH = dfm_pkg::LOG_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_write_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [7:0]         req_frame_control,
   input  logic [15:0]        req_frame_length,
   input  logic [47:0]        req_receiver_address,
   input  logic [47:0]        req_transmitter_address,
   input  logic signed [7:0]  req_signal_strength,
   input  logic [4:0]         req_log_position,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_alert,
   output logic [31:0]        rsp_spike_total,
   output logic [31:0]        rsp_frames_seen,
   output logic [31:0]        rsp_deauth_seen,
   output logic [31:0]        rsp_disassoc_seen,
   output logic [5:0]         rsp_log_fill,
   output logic [3:0]         rsp_channel,
   output logic               rsp_entry_kind,
   output logic [47:0]        rsp_entry_transmitter,
   output logic [47:0]        rsp_entry_receiver,
   output logic signed [7:0]  rsp_entry_rssi
);

   logic                   req_valid_ff, req_valid_in;
   dfm_pkg::cmd_type       cmd_ff;
   logic [7:0]             fc_ff;
   logic [15:0]            len_ff;
   logic [47:0]            rx_ff, tx_ff;
   logic signed [7:0]      rssi_ff;
   logic [4:0]             pos_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   dfm_pkg::status_type    status_ff;
   dfm_pkg::status_type    status;
   dfm_pkg::log_entry_type entry;
   logic                   accept, advance;

   // the input register moves on when the result register is free or draining
   assign advance      = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = req_valid_ff && !advance;
   assign accept       = req_valid && !req_stall;
   assign req_valid_in = accept || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= dfm_pkg::cmd_type'(req_cmd);
         fc_ff   <= req_frame_control;
         len_ff  <= req_frame_length;
         rx_ff   <= req_receiver_address;
         tx_ff   <= req_transmitter_address;
         rssi_ff <= req_signal_strength;
         pos_ff  <= req_log_position;
      end
      if (advance) begin
         status_ff <= status;
      end
   end

   dfm_engine #(
      .LOG_DEPTH (LOG_DEPTH)
   ) u_engine (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .fire                (advance),
      .cmd                 (cmd_ff),
      .frame_control       (fc_ff),
      .frame_length        (len_ff),
      .receiver_address    (rx_ff),
      .transmitter_address (tx_ff),
      .signal_strength     (rssi_ff),
      .log_position        (pos_ff),
      .status              (status),
      .entry               (entry)
   );

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_alert             = status_ff.alert;
   assign rsp_spike_total       = status_ff.spike_total;
   assign rsp_frames_seen       = status_ff.frames_seen;
   assign rsp_deauth_seen       = status_ff.deauth_seen;
   assign rsp_disassoc_seen     = status_ff.disassoc_seen;
   assign rsp_log_fill          = status_ff.log_fill;
   assign rsp_channel           = status_ff.channel;
   // entry fields read as zero unless this transaction read a non-empty log
   assign rsp_entry_kind        = status_ff.entry_hit ? entry.kind : 1'b0;
   assign rsp_entry_transmitter = status_ff.entry_hit ? entry.transmitter : 48'd0;
   assign rsp_entry_receiver    = status_ff.entry_hit ? entry.receiver : 48'd0;
   assign rsp_entry_rssi        = status_ff.entry_hit ? entry.rssi : 8'sd0;

endmodule

// File: tb/tb_deauth_frame_monitor_core.sv
// Self-checking bench for deauth_frame_monitor_core: queued requests, a predictor
// of counters, log ring, timers and alert, and a scoreboard on the result channel.
// Depends on dfm_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_deauth_frame_monitor_core;

   localparam int LOG_DEPTH = dfm_pkg::LOG_DEPTH_DEFAULT;
   localparam int IDLE_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 6;
   localparam int ALERT_TICKS = 40;

   localparam logic [1:0] TYPE_CTRL  = 2'b01;
   localparam logic [1:0] TYPE_DATA  = 2'b10;
   localparam logic [1:0] TYPE_EXT   = 2'b11;
   localparam logic [3:0] SUB_BEACON = 4'h8;
   localparam logic [47:0] ADDR_ONES = '1;

   typedef struct {
      dfm_pkg::cmd_type  cmd;
      logic [7:0]        frame_control;
      logic [15:0]       frame_length;
      logic [47:0]       receiver_address;
      logic [47:0]       transmitter_address;
      logic signed [7:0] signal_strength;
      logic [4:0]        log_position;
   } request_type;

   typedef struct {
      logic              alert;
      logic [31:0]       spike_total;
      logic [31:0]       frames_seen;
      logic [31:0]       deauth_seen;
      logic [31:0]       disassoc_seen;
      logic [5:0]        log_fill;
      logic [3:0]        channel;
      logic              entry_kind;
      logic [47:0]       entry_transmitter;
      logic [47:0]       entry_receiver;
      logic signed [7:0] entry_rssi;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              csr_write_enable = 1'b0;
   logic [1:0]        csr_index = '0;
   logic [15:0]       csr_write_data = '0;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_cmd = '0;
   logic [7:0]        req_frame_control = '0;
   logic [15:0]       req_frame_length = '0;
   logic [47:0]       req_receiver_address = '0;
   logic [47:0]       req_transmitter_address = '0;
   logic signed [7:0] req_signal_strength = '0;
   logic [4:0]        req_log_position = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_alert;
   logic [31:0]       rsp_spike_total;
   logic [31:0]       rsp_frames_seen;
   logic [31:0]       rsp_deauth_seen;
   logic [31:0]       rsp_disassoc_seen;
   logic [5:0]        rsp_log_fill;
   logic [3:0]        rsp_channel;
   logic              rsp_entry_kind;
   logic [47:0]       rsp_entry_transmitter;
   logic [47:0]       rsp_entry_receiver;
   logic signed [7:0] rsp_entry_rssi;

   deauth_frame_monitor_core #(.LOG_DEPTH(LOG_DEPTH)) dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---- predictor state: configuration copy and monitor state
   logic [15:0] cfg_update = dfm_pkg::UPDATE_INTERVAL_RESET;
   logic [15:0] cfg_hop = dfm_pkg::HOP_INTERVAL_RESET;
   logic [15:0] cfg_threshold = dfm_pkg::SPIKE_THRESHOLD_RESET;
   logic        cfg_auto_hop = dfm_pkg::AUTO_HOP_RESET;

   logic [31:0] mgmt_total = '0;
   logic [31:0] deauth_total = '0;
   logic [31:0] disassoc_total = '0;
   logic [31:0] window_deauths = '0;
   logic [31:0] latched_spike = '0;
   logic        alert_on = 1'b0;
   int          log_head = 0;
   int          log_count = 0;
   logic [47:0] log_tx [LOG_DEPTH];
   logic [47:0] log_rx [LOG_DEPTH];
   logic        log_kind [LOG_DEPTH];
   logic [7:0]  log_rssi [LOG_DEPTH];
   logic [3:0]  cur_channel = dfm_pkg::FIRST_CHANNEL;
   logic [15:0] hop_timer = '0;
   logic [15:0] check_timer = '0;

   request_type pending_requests[$];
   result_type  status_due[$];
   int          outstanding = 0;
   int          mismatches = 0;
   int          sender_idle_pct = 10;
   int          receiver_stall_pct = 70;
   int          idle_cycles = 0;

   request_type held_request;
   result_type  predicted;
   result_type  observed;

   // Advances the predicted monitor state by one transaction and returns the status after it.
   task automatic predict_status(input request_type rq, output result_type st);
      logic [1:0] ftype;
      logic [3:0] sub;
      int         pos;
      int         slot;
      begin
         st.entry_kind = 1'b0;
         st.entry_transmitter = '0;
         st.entry_receiver = '0;
         st.entry_rssi = '0;
         case (rq.cmd)
            dfm_pkg::CMD_FRAME: begin
               ftype = rq.frame_control[3:2];
               sub = rq.frame_control[7:4];
               if (rq.frame_length >= dfm_pkg::MIN_HDR_LEN && ftype == dfm_pkg::TYPE_MGMT) begin
                  mgmt_total++;
                  if (sub == dfm_pkg::SUB_DEAUTH || sub == dfm_pkg::SUB_DISASSOC) begin
                     if (sub == dfm_pkg::SUB_DEAUTH) begin
                        deauth_total++;
                        window_deauths++;
                     end else begin
                        disassoc_total++;
                     end
                     log_tx[log_head] = rq.transmitter_address;
                     log_rx[log_head] = rq.receiver_address;
                     log_kind[log_head] = (sub == dfm_pkg::SUB_DISASSOC);
                     log_rssi[log_head] = rq.signal_strength;
                     log_head = (log_head + 1) % LOG_DEPTH;
                     if (log_count < LOG_DEPTH) log_count++;
                  end
               end
            end
            dfm_pkg::CMD_TICK: begin
               // timers keep running (saturating) even while the alert is latched
               if (hop_timer != dfm_pkg::TIMER_MAX) hop_timer++;
               if (check_timer != dfm_pkg::TIMER_MAX) check_timer++;
               if (!alert_on) begin
                  if (cfg_auto_hop && hop_timer >= cfg_hop) begin
                     cur_channel = (cur_channel == dfm_pkg::LAST_CHANNEL) ?
                                   dfm_pkg::FIRST_CHANNEL : cur_channel + 4'd1;
                     hop_timer = '0;
                  end
                  if (check_timer >= cfg_update) begin
                     check_timer = '0;
                     if (window_deauths >= {16'd0, cfg_threshold}) begin
                        latched_spike = window_deauths;
                        alert_on = 1'b1;
                     end
                     window_deauths = '0;
                  end
               end
            end
            dfm_pkg::CMD_DISMISS: begin
               alert_on = 1'b0;
            end
            dfm_pkg::CMD_READ: begin
               if (log_count > 0) begin
                  pos = int'(rq.log_position);
                  if (pos >= log_count) pos = log_count - 1;
                  slot = (log_head + 2 * LOG_DEPTH - 1 - pos) % LOG_DEPTH;
                  st.entry_kind = log_kind[slot];
                  st.entry_transmitter = log_tx[slot];
                  st.entry_receiver = log_rx[slot];
                  st.entry_rssi = log_rssi[slot];
               end
            end
            default: begin
            end
         endcase
         st.alert = alert_on;
         st.spike_total = latched_spike;
         st.frames_seen = mgmt_total;
         st.deauth_seen = deauth_total;
         st.disassoc_seen = disassoc_total;
         st.log_fill = log_count[5:0];
         st.channel = cur_channel;
      end
   endtask

   // ---- driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_status(held_request, predicted);
            status_due.push_back(predicted);
         end
         if (!req_valid || !req_stall) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               held_request = pending_requests.pop_front();
               req_valid <= 1'b1;
               req_cmd <= held_request.cmd;
               req_frame_control <= held_request.frame_control;
               req_frame_length <= held_request.frame_length;
               req_receiver_address <= held_request.receiver_address;
               req_transmitter_address <= held_request.transmitter_address;
               req_signal_strength <= held_request.signal_strength;
               req_log_position <= held_request.log_position;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endtask

   // ---- monitor and scoreboard
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (status_due.size() == 0) begin
               $error("result transaction with no request outstanding");
               $display("SCOREBOARD MISMATCH");
               $finish;
            end else begin
               observed = status_due.pop_front();
               check_field("alert", 64'(observed.alert), 64'(rsp_alert));
               check_field("spike_total", 64'(observed.spike_total), 64'(rsp_spike_total));
               check_field("frames_seen", 64'(observed.frames_seen), 64'(rsp_frames_seen));
               check_field("deauth_seen", 64'(observed.deauth_seen), 64'(rsp_deauth_seen));
               check_field("disassoc_seen", 64'(observed.disassoc_seen),
                           64'(rsp_disassoc_seen));
               check_field("log_fill", 64'(observed.log_fill), 64'(rsp_log_fill));
               check_field("channel", 64'(observed.channel), 64'(rsp_channel));
               check_field("entry_kind", 64'(observed.entry_kind), 64'(rsp_entry_kind));
               check_field("entry_transmitter", 64'(observed.entry_transmitter),
                           64'(rsp_entry_transmitter));
               check_field("entry_receiver", 64'(observed.entry_receiver),
                           64'(rsp_entry_receiver));
               check_field("entry_rssi", 64'(observed.entry_rssi), 64'(rsp_entry_rssi));
               outstanding--;
            end
         end
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // ---- watchdog: no transaction on either channel for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---- stimulus helpers
   function automatic request_type build_request(input dfm_pkg::cmd_type cmd,
                                                 input logic [7:0] fc,
                                                 input logic [15:0] len, input logic [47:0] rx,
                                                 input logic [47:0] tx,
                                                 input logic signed [7:0] rssi,
                                                 input logic [4:0] pos);
      request_type rq;
      rq.cmd = cmd;
      rq.frame_control = fc;
      rq.frame_length = len;
      rq.receiver_address = rx;
      rq.transmitter_address = tx;
      rq.signal_strength = rssi;
      rq.log_position = pos;
      return rq;
   endfunction

   // Deauth/disassoc traffic with other frames, ticks, dismisses and reads, some noise.
   function automatic request_type random_request();
      request_type rq;
      int          pick;
      rq.cmd = dfm_pkg::CMD_FRAME;
      rq.frame_control = 8'($urandom);
      rq.frame_length = 16'($urandom);
      rq.receiver_address = 48'({$urandom, $urandom});
      rq.transmitter_address = 48'({$urandom, $urandom});
      rq.signal_strength = 8'($urandom);
      rq.log_position = 5'($urandom);
      pick = $urandom_range(99);
      if (pick < 42) begin
         rq.frame_control[7:4] = $urandom_range(1) ? dfm_pkg::SUB_DEAUTH : dfm_pkg::SUB_DISASSOC;
         rq.frame_control[3:2] = dfm_pkg::TYPE_MGMT;
         rq.frame_length = $urandom_range(1) ? 16'($urandom_range(400, 24))
                                             : 16'($urandom_range(65535, 24));
      end else if (pick < 50) begin
         rq.frame_control[3:2] = dfm_pkg::TYPE_MGMT;
         rq.frame_length = 16'($urandom_range(65535, 24));
      end else if (pick < 58) begin
         // noise: short frames or random type
         if ($urandom_range(1)) rq.frame_length = 16'($urandom_range(23, 0));
      end else if (pick < 78) begin
         rq.cmd = dfm_pkg::CMD_TICK;
      end else if (pick < 83) begin
         rq.cmd = dfm_pkg::CMD_DISMISS;
      end else begin
         rq.cmd = dfm_pkg::CMD_READ;
      end
      return rq;
   endfunction

   task automatic post(input request_type rq);
      pending_requests.push_back(rq);
      outstanding++;
   endtask

   task automatic post_random(input int count);
      for (int i = 0; i < count; i++) post(random_request());
   endtask

   task automatic drain();
      wait (outstanding == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [15:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (index)
         dfm_pkg::CSR_UPDATE_INTERVAL: cfg_update = value;
         dfm_pkg::CSR_HOP_INTERVAL:    cfg_hop = value;
         dfm_pkg::CSR_SPIKE_THRESHOLD: cfg_threshold = value;
         dfm_pkg::CSR_AUTO_HOP:        cfg_auto_hop = value[0];
         default: begin
         end
      endcase
   endtask

   task automatic reconfigure(input logic [15:0] update_ms, input logic [15:0] hop_ms,
                              input logic [15:0] threshold, input logic auto_hop);
      drain();
      write_register(dfm_pkg::CSR_UPDATE_INTERVAL, update_ms);
      write_register(dfm_pkg::CSR_HOP_INTERVAL, hop_ms);
      write_register(dfm_pkg::CSR_SPIKE_THRESHOLD, threshold);
      write_register(dfm_pkg::CSR_AUTO_HOP, {15'd0, auto_hop});
   endtask

   initial begin
      request_type rq;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: short intervals so ticks hop and raise an alert quickly
      sender_idle_pct = 10;
      receiver_stall_pct = 70;
      reconfigure(16'd2, 16'd1, 16'd1, 1'b1);
      post(build_request(dfm_pkg::CMD_READ, 8'h00, 16'd0, '0, '0, 8'sd0, 5'd0));
      post(build_request(dfm_pkg::CMD_DISMISS, 8'h00, 16'd0, '0, '0, 8'sd0, 5'd0));
      post(build_request(dfm_pkg::CMD_TICK, 8'h00, 16'd0, '0, '0, 8'sd0, 5'd0));
      post(build_request(dfm_pkg::CMD_FRAME, {dfm_pkg::SUB_DEAUTH, dfm_pkg::TYPE_MGMT, 2'b00},
                         16'd23, ADDR_ONES, ADDR_ONES, 8'sd5, 5'd0));
      post(build_request(dfm_pkg::CMD_FRAME, {dfm_pkg::SUB_DEAUTH, TYPE_CTRL, 2'b00}, 16'd24,
                         '0, '0, 8'sd0, 5'd0));
      post(build_request(dfm_pkg::CMD_FRAME, {dfm_pkg::SUB_DEAUTH, TYPE_DATA, 2'b00}, 16'd24,
                         '0, '0, 8'sd0, 5'd0));
      post(build_request(dfm_pkg::CMD_FRAME, {dfm_pkg::SUB_DISASSOC, TYPE_EXT, 2'b11}, 16'd24,
                         '0, '0, 8'sd0, 5'd0));
      post(build_request(dfm_pkg::CMD_FRAME, {SUB_BEACON, dfm_pkg::TYPE_MGMT, 2'b00}, 16'hFFFF,
                         '0, '0, 8'sd0, 5'd0));
      post(build_request(dfm_pkg::CMD_FRAME, {dfm_pkg::SUB_DEAUTH, dfm_pkg::TYPE_MGMT, 2'b00},
                         16'd24, '0, ADDR_ONES, -8'sd128, 5'd0));
      post(build_request(dfm_pkg::CMD_FRAME, {dfm_pkg::SUB_DISASSOC, dfm_pkg::TYPE_MGMT, 2'b00},
                         16'hFFFF, ADDR_ONES, '0, 8'sd127, 5'd0));
      post(build_request(dfm_pkg::CMD_FRAME, {dfm_pkg::SUB_DEAUTH, dfm_pkg::TYPE_MGMT, 2'b11},
                         16'd30, 48'h0123_4567_89AB, 48'hFEDC_BA98_7654, -8'sd1, 5'd0));
      post(build_request(dfm_pkg::CMD_READ, 8'h00, 16'd0, '0, '0, 8'sd0, 5'd0));
      post(build_request(dfm_pkg::CMD_READ, 8'h00, 16'd0, '0, '0, 8'sd0, 5'd1));
      post(build_request(dfm_pkg::CMD_READ, 8'h00, 16'd0, '0, '0, 8'sd0, 5'd2));
      post(build_request(dfm_pkg::CMD_READ, 8'hFF, 16'hFFFF, ADDR_ONES, ADDR_ONES, -8'sd1,
                         5'd31));
      post(build_request(dfm_pkg::CMD_TICK, 8'h00, 16'd0, '0, '0, 8'sd0, 5'd0));
      post(build_request(dfm_pkg::CMD_TICK, 8'h00, 16'd0, '0, '0, 8'sd0, 5'd0));
      // frames while the alert is latched are still counted and logged
      post(build_request(dfm_pkg::CMD_FRAME, {dfm_pkg::SUB_DEAUTH, dfm_pkg::TYPE_MGMT, 2'b00},
                         16'd40, ADDR_ONES, '0, 8'sd64, 5'd0));
      post(build_request(dfm_pkg::CMD_TICK, 8'h00, 16'd0, '0, '0, 8'sd0, 5'd0));
      post(build_request(dfm_pkg::CMD_READ, 8'h00, 16'd0, '0, '0, 8'sd0, 5'd31));
      post(build_request(dfm_pkg::CMD_DISMISS, 8'h00, 16'd0, '0, '0, 8'sd0, 5'd0));
      post(build_request(dfm_pkg::CMD_TICK, 8'h00, 16'd0, '0, '0, 8'sd0, 5'd0));
      post(build_request(dfm_pkg::CMD_FRAME, 8'hFF, 16'd24, '0, '0, 8'sd0, 5'd0));

      reconfigure(16'd7, 16'd3, 16'd3, 1'b1);
      post_random(200);
      drain();   // sender holds off until every result is back
      post_random(250);

      reconfigure(16'd1, 16'd1, 16'd1, 1'b0);
      post_random(300);

      sender_idle_pct = 70;
      receiver_stall_pct = 10;
      // zero intervals and threshold: every allowed tick hops and checks
      reconfigure(16'd0, 16'd0, 16'd0, 1'b1);
      post_random(250);

      reconfigure(16'd20, 16'hFFFF, 16'hFFFF, 1'b1);
      post_random(400);

      // latch an alert, let both timers run past their intervals, then dismiss:
      // the overdue hop and check fire on the first tick after it
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      reconfigure(16'd1, 16'hFFFF, 16'd1, 1'b0);
      post(build_request(dfm_pkg::CMD_FRAME, {dfm_pkg::SUB_DEAUTH, dfm_pkg::TYPE_MGMT, 2'b00},
                         16'd24, ADDR_ONES, '0, 8'sd0, 5'd0));
      post(build_request(dfm_pkg::CMD_TICK, 8'h00, 16'd0, '0, '0, 8'sd0, 5'd0));
      reconfigure(16'd30, 16'd30, 16'd4, 1'b0);
      for (int i = 0; i < ALERT_TICKS; i++) begin
         rq = random_request();
         rq.cmd = dfm_pkg::CMD_TICK;
         post(rq);
      end
      post(build_request(dfm_pkg::CMD_DISMISS, 8'h00, 16'd0, '0, '0, 8'sd0, 5'd0));
      reconfigure(16'd30, 16'd30, 16'd4, 1'b1);
      post(build_request(dfm_pkg::CMD_TICK, 8'h00, 16'd0, '0, '0, 8'sd0, 5'd0));
      post(build_request(dfm_pkg::CMD_TICK, 8'h00, 16'd0, '0, '0, 8'sd0, 5'd0));

      reconfigure(16'd12, 16'd2, 16'd4, 1'b1);
      post_random(450);

      drain();
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/dfm_pkg.sv
rtl/dfm_ram.sv
rtl/dfm_engine.sv
rtl/deauth_frame_monitor_core.sv
tb/tb_deauth_frame_monitor_core.sv
